[design/tlb_page_table_translator_top_defines.svh]
// ---------------------------------------------------------------------------
// TLB translator assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_TOP_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define TLBPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlbpt assertion failed");

// Next-cycle implication.
`define TLBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlbpt assertion failed");

`endif

[design/tlbpt_pkg.sv]
// ---------------------------------------------------------------------------
// TLB translator package
// Sizes, widths and field types shared by the channel interfaces and the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlbpt_pkg;

    localparam int TLB_ENTRIES      = 8;
    localparam int FRAME_COUNT      = 32;
    // power of two: the page number wraps by dropping upper bits
    localparam int VIRTUAL_PAGES    = 64;
    localparam int PAGE_OFFSET_BITS = 10;

    localparam int VA_W   = 16;
    localparam int TIME_W = 32;
    localparam int PA_W   = 15;

    localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FRAME_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int PAGE_W    = $clog2(VIRTUAL_PAGES);

    typedef logic [PAGE_W-1:0]           t_page;
    typedef logic [FRAME_W-1:0]          t_frame;
    typedef logic [TLB_IDX_W-1:0]        t_tlb_idx;
    typedef logic [PAGE_OFFSET_BITS-1:0] t_offset;
    typedef logic [TIME_W-1:0]           t_time;
    typedef logic [PA_W-1:0]             t_paddr;

    typedef struct packed {
        t_paddr physical_address;
        logic   tlb_hit;
        logic   table_hit;
        logic   frame_allocated;
        logic   out_of_frames;
    } t_rsp;

    function automatic t_paddr make_address(input t_frame frame, input t_offset offset);
        return PA_W'({frame, offset});
    endfunction

endpackage

[design/tlbpt_req_if.sv]
// ---------------------------------------------------------------------------
// TLB translator request channel
// Valid/ready channel carrying a virtual address and its time stamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlbpt_req_if;
    logic                       valid;
    logic                       ready;
    logic [tlbpt_pkg::VA_W-1:0]   virtual_address;
    logic [tlbpt_pkg::TIME_W-1:0] request_time;

    modport source (output valid, output virtual_address, output request_time, input ready);
    modport sink   (input valid, input virtual_address, input request_time, output ready);
endinterface

[design/tlbpt_rsp_if.sv]
// ---------------------------------------------------------------------------
// TLB translator response channel
// Valid/ready channel carrying the translated address and status flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlbpt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [tlbpt_pkg::PA_W-1:0] physical_address;
    logic                       tlb_hit;
    logic                       table_hit;
    logic                       frame_allocated;
    logic                       out_of_frames;

    modport source (output valid, output physical_address, output tlb_hit, output table_hit,
                    output frame_allocated, output out_of_frames, input ready);
    modport sink   (input valid, input physical_address, input tlb_hit, input table_hit,
                    input frame_allocated, input out_of_frames, output ready);
endinterface

[design/tlb_page_table_translator_top.sv]
// ---------------------------------------------------------------------------
// TLB page table translator
// Virtual to physical translation through a small fully associative TLB,
// a page table held in a synchronous RAM, and lowest-free frame allocation.
// ---------------------------------------------------------------------------
//
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+-------------
//  i_req    | in  | virtual_address[15:0], request_time[31:0]       | valid/ready
//  o_rsp    | out | physical_address[14:0], tlb_hit, table_hit,     | valid/ready
//           |     | frame_allocated, out_of_frames                  |
//
//  Per item: the accept step issues the page table RAM read; the resolve
//  step uses the registered read data, the TLB compare and the frame search,
//  then writes the RAM, the status bits and the TLB.
//  Reset (synchronous, active low) clears TLB valid, page table valid and
//  frame-used bits at once; the frame RAM needs no clearing.
//  A result waits in the output register; a new item is accepted meanwhile,
//  and the resolve step holds only while that register is full and not taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tlb_page_table_translator_top_defines.svh"

module tlb_page_table_translator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlbpt_req_if.sink   i_req,
    tlbpt_rsp_if.source o_rsp
);

    typedef enum logic {S_IDLE, S_RESOLVE} t_state;

    t_state r_state;

    // page table frame numbers, one entry per virtual page
    tlbpt_pkg::t_frame r_table_mem [tlbpt_pkg::VIRTUAL_PAGES];
    tlbpt_pkg::t_frame r_mem_rd;

    logic [tlbpt_pkg::VIRTUAL_PAGES-1:0] r_table_valid;
    logic [tlbpt_pkg::FRAME_COUNT-1:0]   r_frame_used;

    // TLB entries
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] r_tlb_valid;
    tlbpt_pkg::t_page  r_tlb_page  [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::t_frame r_tlb_frame [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::t_time  r_tlb_time  [tlbpt_pkg::TLB_ENTRIES];

    // item under work
    tlbpt_pkg::t_page   r_page;
    tlbpt_pkg::t_offset r_offset;
    tlbpt_pkg::t_time   r_time;

    tlbpt_pkg::t_rsp r_rsp;
    logic            r_rsp_valid;

    logic              w_accept;
    logic              w_done;
    tlbpt_pkg::t_page  w_in_page;
    logic              w_tlb_hit;
    tlbpt_pkg::t_frame w_tlb_frame;
    logic              w_tbl_valid;
    logic              w_free_found;
    tlbpt_pkg::t_frame w_free_frame;
    logic              w_resolved;
    logic              w_alloc;
    logic              w_none;
    tlbpt_pkg::t_frame w_frame;
    tlbpt_pkg::t_rsp   w_rsp;
    logic                 w_tlb_free_found;
    tlbpt_pkg::t_tlb_idx  w_tlb_free_idx;
    tlbpt_pkg::t_tlb_idx  w_oldest_idx;
    tlbpt_pkg::t_tlb_idx  w_victim;
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] w_is_oldest;

    // no item is taken while reset is held
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_page   = i_req.virtual_address[tlbpt_pkg::PAGE_OFFSET_BITS +: tlbpt_pkg::PAGE_W];
    assign w_done      = (r_state == S_RESOLVE) && (!r_rsp_valid || o_rsp.ready);

    // TLB lookup: lowest matching entry wins
    always_comb begin
        w_tlb_hit   = 1'b0;
        w_tlb_frame = '0;
        for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_page[i] == r_page)) begin
                w_tlb_hit   = 1'b1;
                w_tlb_frame = r_tlb_frame[i];
            end
        end
    end

    // lowest free physical frame
    always_comb begin
        w_free_found = 1'b0;
        w_free_frame = '0;
        for (int i = tlbpt_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
            if (!r_frame_used[i]) begin
                w_free_found = 1'b1;
                w_free_frame = tlbpt_pkg::FRAME_W'(i);
            end
        end
    end

    // refill victim: lowest invalid entry, else oldest fill time (lowest index on ties).
    // Pairwise compares: entry i is oldest when strictly older than every lower
    // entry and no younger than every higher one.
    always_comb begin
        w_tlb_free_found = 1'b0;
        w_tlb_free_idx   = '0;
        w_oldest_idx     = '0;
        for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
            w_is_oldest[i] = 1'b1;
            for (int j = 0; j < tlbpt_pkg::TLB_ENTRIES; j++) begin
                if (j < i && !(r_tlb_time[i] < r_tlb_time[j]))
                    w_is_oldest[i] = 1'b0;
                if (j > i && (r_tlb_time[j] < r_tlb_time[i]))
                    w_is_oldest[i] = 1'b0;
            end
        end
        for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
            if (!r_tlb_valid[i]) begin
                w_tlb_free_found = 1'b1;
                w_tlb_free_idx   = tlbpt_pkg::TLB_IDX_W'(i);
            end
            if (w_is_oldest[i])
                w_oldest_idx = tlbpt_pkg::TLB_IDX_W'(i);
        end
        w_victim = w_tlb_free_found ? w_tlb_free_idx : w_oldest_idx;
    end

    // resolution of the item under work
    always_comb begin
        w_tbl_valid = r_table_valid[r_page];
        w_resolved  = !w_tlb_hit && (w_tbl_valid || w_free_found);
        w_alloc     = !w_tlb_hit && !w_tbl_valid && w_free_found;
        w_none      = !w_tlb_hit && !w_tbl_valid && !w_free_found;
        w_frame     = w_tbl_valid ? r_mem_rd : w_free_frame;

        w_rsp.tlb_hit         = w_tlb_hit;
        w_rsp.table_hit       = w_resolved;
        w_rsp.frame_allocated = w_alloc;
        w_rsp.out_of_frames   = w_none;
        priority if (w_tlb_hit)
            w_rsp.physical_address = tlbpt_pkg::make_address(w_tlb_frame, r_offset);
        else if (w_resolved)
            w_rsp.physical_address = tlbpt_pkg::make_address(w_frame, r_offset);
        else
            w_rsp.physical_address = '0;
    end

    // control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rsp_valid   <= 1'b0;
            r_table_valid <= '0;
            r_frame_used  <= '0;
            r_tlb_valid   <= '0;
        end else begin
            if (o_rsp.ready && !w_done)
                r_rsp_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept)
                        r_state <= S_RESOLVE;
                end
                S_RESOLVE: begin
                    if (w_done) begin
                        r_state     <= S_IDLE;
                        r_rsp_valid <= 1'b1;
                        r_rsp       <= w_rsp;
                        if (w_alloc) begin
                            r_frame_used[w_free_frame] <= 1'b1;
                            r_table_valid[r_page]      <= 1'b1;
                        end
                        if (w_resolved)
                            r_tlb_valid[w_victim] <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item payload and TLB entry contents
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= w_in_page;
            r_offset <= i_req.virtual_address[tlbpt_pkg::PAGE_OFFSET_BITS-1:0];
            r_time   <= i_req.request_time;
        end
        if (w_done && w_resolved) begin
            r_tlb_page[w_victim]  <= r_page;
            r_tlb_frame[w_victim] <= w_frame;
            r_tlb_time[w_victim]  <= r_time;
        end
    end

    // page table RAM: read at accept, written on allocation; the next read
    // is issued only after the write edge, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (w_done && w_alloc)
            r_table_mem[r_page] <= w_free_frame;
        if (w_accept)
            r_mem_rd <= r_table_mem[w_in_page];
    end

    assign o_rsp.valid            = r_rsp_valid;
    assign o_rsp.physical_address = r_rsp.physical_address;
    assign o_rsp.tlb_hit          = r_rsp.tlb_hit;
    assign o_rsp.table_hit        = r_rsp.table_hit;
    assign o_rsp.frame_allocated  = r_rsp.frame_allocated;
    assign o_rsp.out_of_frames    = r_rsp.out_of_frames;

    `TLBPT_ASSERT_NEXT(a_accept_resolves, i_clk, i_rst_n, w_accept, r_state == S_RESOLVE)
    `TLBPT_ASSERT_NOW(a_none_means_full, i_clk, i_rst_n, w_done && w_none, &r_frame_used)
    `TLBPT_ASSERT_NEXT(a_refill_valid, i_clk, i_rst_n, w_done && w_resolved,
                       r_tlb_valid[$past(w_victim)] && o_rsp.valid)
    `TLBPT_ASSERT_NOW(a_flags_consistent, i_clk, i_rst_n, o_rsp.valid,
                      !(o_rsp.tlb_hit && o_rsp.table_hit) &&
                      (!o_rsp.frame_allocated || o_rsp.table_hit))

endmodule
